// ===== rtl/htms_pkg.sv =====
package htms_pkg;

  localparam int unsigned AxisBitsDef = 16;
  localparam int unsigned FuncBits    = 3;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 8;
  localparam int unsigned HoldBits    = 8;

  // request codes
  localparam logic [FuncBits-1:0] FuncJoy     = 3'd0;
  localparam logic [FuncBits-1:0] FuncTick    = 3'd1;
  localparam logic [FuncBits-1:0] FuncTeleop  = 3'd2;
  localparam logic [FuncBits-1:0] FuncPlanner = 3'd3;
  localparam logic [FuncBits-1:0] FuncSetMode = 3'd4;

  // register indexes
  localparam logic [CfgIdxBits-1:0] RegUseTwoKeys   = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegFirstIsAxis  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegSecondIsAxis = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegHoldTicks    = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegStartMode    = 3'd4;

  localparam logic                UseTwoKeysRst = 1'b1;
  localparam logic                FirstAxisRst  = 1'b0;
  localparam logic                SecondAxisRst = 1'b0;
  localparam logic [HoldBits-1:0] HoldTicksRst  = 8'd50;
  localparam logic                StartModeRst  = 1'b0;
  localparam logic [HoldBits-1:0] HoldTicksMax  = 8'd250;
  localparam logic [HoldBits-1:0] HoldCountMax  = 8'd255;

  typedef struct packed {
    logic                two_keys_en;
    logic                first_is_axis;
    logic                second_is_axis;
    logic [HoldBits-1:0] hold_limit;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic mode;
  } preset_t;

  typedef struct packed {
    logic mode_now;
    logic keys_down_now;
    logic forward_velocity;
    logic send_stop;
  } res_t;

endpackage

// ===== rtl/htms_if.sv =====
interface htms_req_if #(
  parameter int unsigned AXIS_BITS = htms_pkg::AxisBitsDef
) ();
  logic                       valid;
  logic                       ready;
  logic [2:0]                 func;
  logic signed [AXIS_BITS-1:0] first_axis;
  logic                       first_button;
  logic signed [AXIS_BITS-1:0] second_axis;
  logic                       second_button;
  logic                       set_autonomous;

  modport source (
    output valid, func, first_axis, first_button, second_axis, second_button,
           set_autonomous,
    input  ready
  );
  modport sink (
    input  valid, func, first_axis, first_button, second_axis, second_button,
           set_autonomous,
    output ready
  );
endinterface

interface htms_res_if ();
  logic valid;
  logic ready;
  logic mode_now;
  logic keys_down_now;
  logic forward_velocity;
  logic send_stop;

  modport source (
    output valid, mode_now, keys_down_now, forward_velocity, send_stop,
    input  ready
  );
  modport sink (
    input  valid, mode_now, keys_down_now, forward_velocity, send_stop,
    output ready
  );
endinterface

// ===== rtl/hold_to_toggle_mode_selector.sv =====
// Hold-to-toggle mode selector: teleop / autonomous arbitration from operator
// input events.
// req_i carries one event per request (joystick report, loop tick, teleop or
// planner velocity command, set-mode request); res_o returns exactly one
// result per request: current mode, qualified key state, whether a velocity
// command passes and whether a stop command must be sent.
// The cfg_* port writes the five settings by index; writes to start_mode also
// preset the mode at once. Write only while no request is in flight.
// A request accepted into the input register has its result captured in the
// result register once that register can take it.
// Throughput: one request per cycle while res_o is not stalled, set by the
// state update between the input register and the result register.
// A stalled receiver holds the result register; one further request is held
// in the input register, after which req_i.ready drops until res_o drains.
// Reset clears both pipeline stages, loads the default settings and puts
// the block in teleop mode with no hold in progress.
module hold_to_toggle_mode_selector #(
  parameter int unsigned AXIS_BITS = htms_pkg::AxisBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  htms_req_if.sink                         req_i,
  htms_res_if.source                       res_o,
  input  logic                             cfg_we_i,
  input  logic [htms_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [htms_pkg::CfgDataBits-1:0] cfg_data_i
);
  import htms_pkg::*;

  cfg_t    cfg;
  preset_t preset;
  res_t    st_res;
  res_t    res_q;
  logic    res_vld_q;
  logic    s1_vld_q;
  logic    res_take;
  logic    s2_fire;
  logic    keys_down;
  logic    keys_new;

  logic [FuncBits-1:0]         func_q;
  logic signed [AXIS_BITS-1:0] first_axis_q;
  logic                        first_button_q;
  logic signed [AXIS_BITS-1:0] second_axis_q;
  logic                        second_button_q;
  logic                        set_auto_q;

  assign res_take    = !res_vld_q || res_o.ready;
  assign s2_fire     = s1_vld_q && res_take;
  assign req_i.ready = !s1_vld_q || res_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q          <= req_i.func;
      first_axis_q    <= req_i.first_axis;
      first_button_q  <= req_i.first_button;
      second_axis_q   <= req_i.second_axis;
      second_button_q <= req_i.second_button;
      set_auto_q      <= req_i.set_autonomous;
    end
  end

  htms_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .preset_o   (preset)
  );

  htms_key_qual #(
    .AXIS_BITS (AXIS_BITS)
  ) u_key_qual (
    .cfg_i           (cfg),
    .keys_down_i     (keys_down),
    .first_axis_i    (first_axis_q),
    .first_button_i  (first_button_q),
    .second_axis_i   (second_axis_q),
    .second_button_i (second_button_q),
    .keys_o          (keys_new)
  );

  htms_state u_state (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .en_i             (s2_fire),
    .func_i           (func_q),
    .set_autonomous_i (set_auto_q),
    .keys_new_i       (keys_new),
    .cfg_i            (cfg),
    .preset_i         (preset),
    .keys_down_o      (keys_down),
    .res_o            (st_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_take) begin
      res_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      res_q <= st_res;
    end
  end

  assign res_o.valid            = res_vld_q;
  assign res_o.mode_now         = res_q.mode_now;
  assign res_o.keys_down_now    = res_q.keys_down_now;
  assign res_o.forward_velocity = res_q.forward_velocity;
  assign res_o.send_stop        = res_q.send_stop;

  // a stop only comes from a tick, never with a forwarded velocity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !(res_q.send_stop && res_q.forward_velocity))
    else $error("stop and forward flagged together");

  // a toggle needs the keys held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_fire && st_res.send_stop) |-> (func_q == FuncTick) && st_res.keys_down_now)
    else $error("toggle without held keys on a tick");

  // a buffered request is not dropped while the result stage is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && !res_take) |=> s1_vld_q)
    else $error("buffered request lost");

endmodule

// ===== rtl/htms_cfg.sv =====
module htms_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [htms_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [htms_pkg::CfgDataBits-1:0]    cfg_data_i,
  output htms_pkg::cfg_t                      cfg_o,
  output htms_pkg::preset_t                   preset_o
);
  import htms_pkg::*;

  logic                use_two_q;
  logic                first_axis_q;
  logic                second_axis_q;
  logic [HoldBits-1:0] hold_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_two_q     <= UseTwoKeysRst;
      first_axis_q  <= FirstAxisRst;
      second_axis_q <= SecondAxisRst;
      hold_ticks_q  <= HoldTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegUseTwoKeys:   use_two_q     <= cfg_data_i[0];
        RegFirstIsAxis:  first_axis_q  <= cfg_data_i[0];
        RegSecondIsAxis: second_axis_q <= cfg_data_i[0];
        RegHoldTicks:    hold_ticks_q  <= cfg_data_i[HoldBits-1:0];
        default: ;
      endcase
    end
  end

  // hold time clamped to HoldTicksMax ticks
  always_comb begin
    cfg_o.two_keys_en    = use_two_q;
    cfg_o.first_is_axis  = first_axis_q;
    cfg_o.second_is_axis = second_axis_q;
    cfg_o.hold_limit     = (hold_ticks_q > HoldTicksMax) ? HoldTicksMax : hold_ticks_q;
  end

  assign preset_o.en   = cfg_we_i && (cfg_idx_i == RegStartMode);
  assign preset_o.mode = cfg_data_i[0];

endmodule

// ===== rtl/htms_key_qual.sv =====
module htms_key_qual #(
  parameter int unsigned AXIS_BITS = htms_pkg::AxisBitsDef
) (
  input  htms_pkg::cfg_t              cfg_i,
  input  logic                        keys_down_i,
  input  logic signed [AXIS_BITS-1:0] first_axis_i,
  input  logic                        first_button_i,
  input  logic signed [AXIS_BITS-1:0] second_axis_i,
  input  logic                        second_button_i,
  output logic                        keys_o
);
  import htms_pkg::*;

  localparam logic signed [AXIS_BITS-1:0] HalfPos = {2'b01, {(AXIS_BITS-2){1'b0}}};
  localparam logic signed [AXIS_BITS-1:0] HalfNeg = {2'b11, {(AXIS_BITS-2){1'b0}}};

  logic first_axis_on;
  logic second_axis_on;
  logic key_one;
  logic key_two;

  // hysteresis follows the combined key state
  assign first_axis_on  = keys_down_i ? !(first_axis_i > HalfPos) : (first_axis_i < HalfNeg);
  assign second_axis_on = keys_down_i ? !(second_axis_i > HalfPos) : (second_axis_i < HalfNeg);

  assign key_one = cfg_i.first_is_axis  ? first_axis_on  : first_button_i;
  assign key_two = cfg_i.second_is_axis ? second_axis_on : second_button_i;

  assign keys_o = key_one && (key_two || !cfg_i.two_keys_en);

endmodule

// ===== rtl/htms_state.sv =====
module htms_state (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [htms_pkg::FuncBits-1:0]   func_i,
  input  logic                            set_autonomous_i,
  input  logic                            keys_new_i,
  input  htms_pkg::cfg_t                  cfg_i,
  input  htms_pkg::preset_t               preset_i,
  output logic                            keys_down_o,
  output htms_pkg::res_t                  res_o
);
  import htms_pkg::*;

  logic                autonomous_q, autonomous_d;
  logic                keys_down_q, keys_down_d;
  logic                hold_q, hold_d;
  logic                toggled_q, toggled_d;
  logic [HoldBits-1:0] count_q, count_d;
  logic [HoldBits-1:0] count_inc;
  logic                fwd;
  logic                stop;

  assign count_inc = (count_q == HoldCountMax) ? count_q : count_q + 8'd1;

  always_comb begin
    autonomous_d = autonomous_q;
    keys_down_d  = keys_down_q;
    hold_d       = hold_q;
    toggled_d    = toggled_q;
    count_d      = count_q;
    fwd          = 1'b0;
    stop         = 1'b0;
    case (func_i)
      FuncJoy: begin
        keys_down_d = keys_new_i;
      end
      FuncTick: begin
        if (!hold_q && keys_down_q) begin
          hold_d  = 1'b1;
          count_d = '0;
        end else if (hold_q && !keys_down_q) begin
          hold_d    = 1'b0;
          toggled_d = 1'b0;
        end else if (hold_q && keys_down_q && !toggled_q) begin
          count_d = count_inc;
          if (count_inc >= cfg_i.hold_limit) begin
            autonomous_d = !autonomous_q;
            stop         = 1'b1;
            toggled_d    = 1'b1;
          end
        end
      end
      FuncTeleop:  fwd = !autonomous_q;
      FuncPlanner: fwd = autonomous_q;
      FuncSetMode: autonomous_d = set_autonomous_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      autonomous_q <= StartModeRst;
      keys_down_q  <= 1'b0;
      hold_q       <= 1'b0;
      toggled_q    <= 1'b0;
      count_q      <= '0;
    end else begin
      if (en_i) begin
        autonomous_q <= autonomous_d;
        keys_down_q  <= keys_down_d;
        hold_q       <= hold_d;
        toggled_q    <= toggled_d;
        count_q      <= count_d;
      end
      if (preset_i.en) begin
        autonomous_q <= preset_i.mode;
      end
    end
  end

  assign keys_down_o          = keys_down_q;
  assign res_o.mode_now         = autonomous_d;
  assign res_o.keys_down_now    = keys_down_d;
  assign res_o.forward_velocity = fwd;
  assign res_o.send_stop        = stop;

endmodule
